>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the calendar clock RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge out of reset
`define MTCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// ante implies cons in the same cycle
`define MTCC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define MTCC_ASSERT(lbl, prop, msg)
`define MTCC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/mtcc_pkg.sv
// ----------------------------------------------------------------------------
// mtcc_pkg
// Types and constants of the millisecond tick calendar clock.
// ----------------------------------------------------------------------------
package mtcc_pkg;

  localparam logic [15:0] TICKS_PER_SEC_RST = 16'd1000;
  localparam logic [15:0] STARTUP_DELAY_RST = 16'd1000;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic {
    REG_TICKS_PER_SEC = 1'b0,
    REG_STARTUP_DELAY = 1'b1
  } reg_idx_t;

  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [2:0]  WDAY_FIRST = 3'd1;
  localparam logic [2:0]  WDAY_LAST  = 3'd7;
  localparam logic [4:0]  DAY_FIRST  = 5'd1;
  localparam logic [3:0]  MON_FIRST  = 4'd1;
  localparam logic [3:0]  MON_FEB    = 4'd2;
  localparam logic [3:0]  MON_LAST   = 4'd12;
  localparam logic [15:0] YEAR_LAST  = 16'hFFFF;
  localparam logic [8:0]  Y400_LAST  = 9'd399;
  localparam logic [8:0]  Y400_C1    = 9'd100;
  localparam logic [8:0]  Y400_C2    = 9'd200;
  localparam logic [8:0]  Y400_C3    = 9'd300;

  typedef struct packed {
    logic [15:0] ticks_per_second;
    logic [15:0] startup_delay;
  } cfg_t;

  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [15:0] year;
    logic        running;
    logic        second_strobe;
  } time_t;

  // days per month, February 28; code 0 and unused codes give 0
  function automatic logic [4:0] month_days(input logic [3:0] mon);
    logic [4:0] d;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
      4'd2:                                      d = 5'd28;
      default:                                   d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/mtcc_in_if.sv
// ----------------------------------------------------------------------------
// mtcc_in_if
// Tick channel: each word carries a tick flag that marks an elapsed timer tick.
// ----------------------------------------------------------------------------
interface mtcc_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

>>> hw/rtl/mtcc_out_if.sv
// ----------------------------------------------------------------------------
// mtcc_out_if
// Result channel: full calendar time per word.
// ----------------------------------------------------------------------------
interface mtcc_out_if;
  logic          valid;
  logic          ready;
  mtcc_pkg::time_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/mtcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mtcc_cfg_regs
// APB register file: ticks per second and startup delay.
// ----------------------------------------------------------------------------
module mtcc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mtcc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [mtcc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [mtcc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output mtcc_pkg::cfg_t                    cfg
);

  mtcc_pkg::cfg_t     cfg_r;
  mtcc_pkg::reg_idx_t idx;
  logic               wr_en;
  logic [15:0]        rd_val;

  assign cfg_pready = 1'b1;
  assign idx        = mtcc_pkg::reg_idx_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (idx)
      mtcc_pkg::REG_TICKS_PER_SEC: rd_val = cfg_r.ticks_per_second;
      mtcc_pkg::REG_STARTUP_DELAY: rd_val = cfg_r.startup_delay;
      default:                     rd_val = '0;
    endcase
  end

  assign cfg_prdata = {{(mtcc_pkg::CFG_DATA_W-16){1'b0}}, rd_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_second <= mtcc_pkg::TICKS_PER_SEC_RST;
      cfg_r.startup_delay    <= mtcc_pkg::STARTUP_DELAY_RST;
    end else if (wr_en) begin
      unique case (idx)
        mtcc_pkg::REG_TICKS_PER_SEC: cfg_r.ticks_per_second <= cfg_pwdata[15:0];
        mtcc_pkg::REG_STARTUP_DELAY: cfg_r.startup_delay    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/mtcc_calendar.sv
// ----------------------------------------------------------------------------
// mtcc_calendar
// Calendar state and its one-tick carry chain; gives the time after the tick.
// ----------------------------------------------------------------------------
module mtcc_calendar (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            tick,
  input  mtcc_pkg::cfg_t  cfg,
  output mtcc_pkg::time_t res
);

  logic [15:0] sub_r, sub_nxt, sub_inc;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic [4:0]  day_r, day_nxt, day_inc, mon_len;
  logic [3:0]  mon_r, mon_nxt;
  logic [15:0] year_r, year_nxt;
  logic [8:0]  y400_r, y400_nxt;
  logic [15:0] scnt_r, scnt_nxt;
  logic        run_r, run_nxt;

  logic tick_en, sec_adv, min_adv, hour_adv, day_adv, mon_adv, year_adv;
  logic leap, mon_end;

  assign tick_en = step && tick;
  assign sub_inc = sub_r + 16'd1;
  assign sec_adv = tick_en && (sub_inc >= cfg.ticks_per_second);
  assign sub_nxt = !tick_en ? sub_r : (sec_adv ? 16'd0 : sub_inc);

  assign min_adv  = sec_adv  && (sec_r  == mtcc_pkg::SEC_LAST);
  assign hour_adv = min_adv  && (min_r  == mtcc_pkg::MIN_LAST);
  assign day_adv  = hour_adv && (hour_r == mtcc_pkg::HOUR_LAST);

  assign sec_nxt  = !sec_adv  ? sec_r  : (min_adv  ? 6'd0 : sec_r  + 6'd1);
  assign min_nxt  = !min_adv  ? min_r  : (hour_adv ? 6'd0 : min_r  + 6'd1);
  assign hour_nxt = !hour_adv ? hour_r : (day_adv  ? 5'd0 : hour_r + 5'd1);

  assign wday_nxt = !day_adv ? wday_r :
                    ((wday_r == mtcc_pkg::WDAY_LAST) ? mtcc_pkg::WDAY_FIRST : wday_r + 3'd1);

  // year mod 400 tracks the century rule
  assign leap = (y400_r[1:0] == 2'd0) && (y400_r != mtcc_pkg::Y400_C1) &&
                (y400_r != mtcc_pkg::Y400_C2) && (y400_r != mtcc_pkg::Y400_C3);

  assign mon_len = mtcc_pkg::month_days(mon_r) +
                   {4'd0, (mon_r == mtcc_pkg::MON_FEB) && leap};
  assign day_inc = day_r + 5'd1;
  assign mon_end = (day_inc > mon_len) || (day_inc == 5'd0);

  assign mon_adv  = day_adv && mon_end;
  assign year_adv = mon_adv && (mon_r >= mtcc_pkg::MON_LAST);

  assign day_nxt  = !day_adv ? day_r : (mon_end ? mtcc_pkg::DAY_FIRST : day_inc);
  assign mon_nxt  = !mon_adv ? mon_r : (year_adv ? mtcc_pkg::MON_FIRST : mon_r + 4'd1);
  assign year_nxt = !year_adv ? year_r : year_r + 16'd1;
  assign y400_nxt = !year_adv ? y400_r :
                    ((year_r == mtcc_pkg::YEAR_LAST) || (y400_r == mtcc_pkg::Y400_LAST)) ?
                    9'd0 : y400_r + 9'd1;

  assign run_nxt  = run_r || (tick_en && (scnt_r == cfg.startup_delay));
  assign scnt_nxt = (tick_en && !run_r) ? scnt_r + 16'd1 : scnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r  <= '0;
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
      wday_r <= mtcc_pkg::WDAY_FIRST;
      day_r  <= mtcc_pkg::DAY_FIRST;
      mon_r  <= mtcc_pkg::MON_FIRST;
      year_r <= '0;
      y400_r <= '0;
      scnt_r <= '0;
      run_r  <= 1'b0;
    end else begin
      sub_r  <= sub_nxt;
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      wday_r <= wday_nxt;
      day_r  <= day_nxt;
      mon_r  <= mon_nxt;
      year_r <= year_nxt;
      y400_r <= y400_nxt;
      scnt_r <= scnt_nxt;
      run_r  <= run_nxt;
    end
  end

  always_comb begin
    res.seconds       = sec_nxt;
    res.minutes       = min_nxt;
    res.hours         = hour_nxt;
    res.weekday       = wday_nxt;
    res.day_of_month  = day_nxt;
    res.month         = mon_nxt;
    res.year          = year_nxt;
    res.running       = run_nxt;
    res.second_strobe = sec_adv;
  end

endmodule

>>> hw/rtl/millisecond_tick_calendar_clock_unit.sv
// ----------------------------------------------------------------------------
// millisecond_tick_calendar_clock_unit
// Tick-driven calendar clock with startup flag and APB configuration.
// ----------------------------------------------------------------------------
// The result word is registered at the edge that takes the tick.
// Throughput: one tick word per cycle; the output register takes a new word
// whenever it is empty or being drained in the same cycle.
// Reset (synchronous, rst_n low): time 00:00:00, weekday 1, day 1, month 1,
// year 0, startup flag clear, registers at 1000; no result word pending.
`include "assert_macros.svh"

module millisecond_tick_calendar_clock_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  mtcc_in_if.sink                         in_ch,
  mtcc_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mtcc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mtcc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mtcc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  mtcc_pkg::cfg_t  cfg;
  mtcc_pkg::time_t res;
  mtcc_pkg::time_t out_data_r;
  logic            out_vld_r, out_vld_nxt;
  logic            in_acc;

  mtcc_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  mtcc_calendar u_cal (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_acc),
    .tick  (in_ch.tick),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_vld_nxt = in_acc || (out_vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      out_data_r <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (in_acc) begin
        out_data_r <= res;
      end
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  `MTCC_ASSERT(a_no_overwrite, !(in_acc && out_vld_r && !out_ch.ready), "pending word overwritten")
  `MTCC_ASSERT(a_run_sticky, !$fell(out_data_r.running), "running flag dropped")
  `MTCC_ASSERT_IMPL(a_word_from_tick, $rose(out_vld_r), $past(in_acc), "word without tick")
  `MTCC_ASSERT_IMPL(a_time_range, out_vld_r, (out_data_r.seconds <= mtcc_pkg::SEC_LAST) && (out_data_r.minutes <= mtcc_pkg::MIN_LAST) && (out_data_r.hours <= mtcc_pkg::HOUR_LAST), "time field out of range")

endmodule

>>> verif/millisecond_tick_calendar_clock_unit_test.sv
// ----------------------------------------------------------------------------
// millisecond_tick_calendar_clock_unit_test
// Drives tick words into the calendar clock and checks every time word
// against a cycle-free calendar predictor kept inside the bench. Covers
// register extremes, lowered rate and startup delay, idle ticks, random
// phases with random idling on both channels, and a run at one tick per
// second that carries the seconds into the minutes.
// ----------------------------------------------------------------------------
module millisecond_tick_calendar_clock_unit_test;
  import mtcc_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int REPORT_CAP  = 20;
  localparam int ROLL_TICKS  = 2 * 60;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  mtcc_in_if  tick_if ();
  mtcc_out_if time_if ();

  millisecond_tick_calendar_clock_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (tick_if),
    .out_ch      (time_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // calendar predictor state
  logic [15:0] rate_limit  = TICKS_PER_SEC_RST;
  logic [15:0] start_limit = STARTUP_DELAY_RST;
  logic [15:0] subtick     = '0;
  logic [5:0]  sec_now     = '0;
  logic [5:0]  min_now     = '0;
  logic [4:0]  hour_now    = '0;
  logic [2:0]  wday_now    = WDAY_FIRST;
  logic [4:0]  mday_now    = DAY_FIRST;
  logic [3:0]  mon_now     = MON_FIRST;
  logic [15:0] year_now    = '0;
  logic [15:0] start_cnt   = '0;
  logic        running_now = 1'b0;
  logic [4:0]  days_per_month [0:12] =
    '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  time_t calendar_q[$];
  bit    idle_en;
  int    mismatches;
  int    words_sent;
  int    results_seen;
  int    reg_writes;
  int    quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit leap_year(input logic [15:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic time_t step_calendar(input logic t);
    time_t      r;
    logic       strobe;
    logic [4:0] mlen;
    strobe = 1'b0;
    if (t) begin
      subtick = subtick + 16'd1;
      if (subtick >= rate_limit) begin
        subtick = '0;
        strobe  = 1'b1;
        sec_now = sec_now + 6'd1;
        if (sec_now > SEC_LAST) begin
          sec_now = '0;
          min_now = min_now + 6'd1;
          if (min_now > MIN_LAST) begin
            min_now  = '0;
            hour_now = hour_now + 5'd1;
            if (hour_now > HOUR_LAST) begin
              hour_now = '0;
              wday_now = (wday_now == WDAY_LAST) ? WDAY_FIRST : wday_now + 3'd1;
              mday_now = mday_now + 5'd1;
              mlen     = days_per_month[(mon_now <= MON_LAST) ? mon_now : 4'd0];
              if (mon_now == MON_FEB && leap_year(year_now)) mlen = mlen + 5'd1;
              if (mday_now > mlen || mday_now == '0) begin
                mday_now = DAY_FIRST;
                mon_now  = mon_now + 4'd1;
                if (mon_now > MON_LAST) begin
                  mon_now  = MON_FIRST;
                  year_now = year_now + 16'd1;
                end
              end
            end
          end
        end
      end
      if (!running_now) begin
        if (start_cnt == start_limit) running_now = 1'b1;
        start_cnt = start_cnt + 16'd1;
      end
    end
    r.seconds       = sec_now;
    r.minutes       = min_now;
    r.hours         = hour_now;
    r.weekday       = wday_now;
    r.day_of_month  = mday_now;
    r.month         = mon_now;
    r.year          = year_now;
    r.running       = running_now;
    r.second_strobe = strobe;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < REPORT_CAP)
      $display("mismatch %s: got %0d, want %0d (word %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  task automatic send_word(input logic t);
    int gap;
    gap = idle_en ? $urandom_range(9, 0) : 0;
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_if.valid <= 1'b1;
    tick_if.tick  <= t;
    do @(posedge clk); while (!tick_if.ready);
    calendar_q.push_back(step_calendar(t));
    words_sent++;
  endtask

  // drop valid and hold until every pending time word has come back
  task automatic settle_outputs();
    tick_if.valid <= 1'b0;
    while (calendar_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input reg_idx_t r, input logic [15:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= {16'b0, wdata};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
  endtask

  task automatic program_register(input reg_idx_t r, input logic [15:0] v);
    logic [CFG_DATA_W-1:0] rdata;
    settle_outputs();
    apb_access(1'b1, r, v, rdata);
    apb_access(1'b0, r, '0, rdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rdata !== {16'b0, v}) report_mismatch(r.name(), rdata, v);
    case (r)
      REG_TICKS_PER_SEC: rate_limit  = v;
      REG_STARTUP_DELAY: start_limit = v;
    endcase
    reg_writes++;
  endtask

  task automatic test_reset_state();
    idle_en = 1'b1;
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b1);
  endtask

  task automatic test_register_extremes();
    program_register(REG_TICKS_PER_SEC, 16'hFFFF);
    program_register(REG_STARTUP_DELAY, 16'hFFFF);
    repeat (2) send_word(1'b1);
    // subtick already past the new rate: next tick must strobe
    program_register(REG_TICKS_PER_SEC, 16'd1);
    repeat (3) send_word(1'b1);
    send_word(1'b0);
    program_register(REG_TICKS_PER_SEC, 16'd0);
    repeat (3) send_word(1'b1);
    send_word(1'b0);
    // startup count already past zero: flag must wait for the wrap
    program_register(REG_STARTUP_DELAY, 16'd0);
    repeat (2) send_word(1'b1);
  endtask

  task automatic test_lowered_rate();
    program_register(REG_TICKS_PER_SEC, 16'd4);
    repeat (6) send_word(1'b1);
  endtask

  task automatic test_random_phases();
    logic [15:0] v;
    repeat (5) begin
      case ($urandom_range(4, 0))
        0: v = 16'd0;
        1: v = 16'($urandom_range(3, 1));
        2: v = 16'($urandom_range(60, 4));
        3: v = 16'hFFFF;
        default: v = 16'($urandom);
      endcase
      program_register(REG_TICKS_PER_SEC, v);
      case ($urandom_range(2, 0))
        0: v = 16'd0;
        1: v = 16'hFFFF;
        default: v = 16'($urandom);
      endcase
      program_register(REG_STARTUP_DELAY, v);
      idle_en = ($urandom_range(3, 0) != 0);
      for (int i = 0; i < 200; i++) begin
        if (i == 100) settle_outputs();
        send_word($urandom_range(9, 0) != 0);
      end
    end
  endtask

  // one tick per second, back to back: carries the seconds into the minutes;
  // a startup delay just ahead of the count makes the flag rise midway
  task automatic test_minute_rollover();
    program_register(REG_TICKS_PER_SEC, 16'd1);
    if (!running_now) program_register(REG_STARTUP_DELAY, start_cnt + 16'd60);
    idle_en = 1'b0;
    repeat (ROLL_TICKS) send_word(1'b1);
  endtask

  initial begin
    time_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int stall;
      stall = idle_en ? $urandom_range(9, 0) : 0;
      if (stall > 0) begin
        time_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      time_if.ready <= 1'b1;
      do @(posedge clk); while (!time_if.valid);
    end
  end

  always @(posedge clk) begin : check_results
    time_t got;
    time_t want;
    if (rst_n && time_if.valid && time_if.ready) begin
      got = time_if.data;
      if (calendar_q.size() == 0) begin
        report_mismatch("unexpected time word", 1, 0);
      end else begin
        want = calendar_q.pop_front();
        if (got.seconds !== want.seconds)
          report_mismatch("seconds", got.seconds, want.seconds);
        if (got.minutes !== want.minutes)
          report_mismatch("minutes", got.minutes, want.minutes);
        if (got.hours !== want.hours)
          report_mismatch("hours", got.hours, want.hours);
        if (got.weekday !== want.weekday)
          report_mismatch("weekday", got.weekday, want.weekday);
        if (got.day_of_month !== want.day_of_month)
          report_mismatch("day_of_month", got.day_of_month, want.day_of_month);
        if (got.month !== want.month)
          report_mismatch("month", got.month, want.month);
        if (got.year !== want.year)
          report_mismatch("year", got.year, want.year);
        if (got.running !== want.running)
          report_mismatch("running", got.running, want.running);
        if (got.second_strobe !== want.second_strobe)
          report_mismatch("second_strobe", got.second_strobe, want.second_strobe);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((tick_if.valid && tick_if.ready) || (time_if.valid && time_if.ready) || cfg_psel)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", quiet_cycles);
        $display("[millisecond_tick_calendar_clock_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    tick_if.valid = 1'b0;
    tick_if.tick  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    idle_en       = 1'b1;
    mismatches    = 0;
    words_sent    = 0;
    reg_writes    = 0;
    rst_n         = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_register_extremes();
    test_lowered_rate();
    test_random_phases();
    test_minute_rollover();

    settle_outputs();
    repeat (4) @(posedge clk);
    $display("covered %0d tick words, %0d time words checked, %0d register writes",
             words_sent, results_seen, reg_writes);
    $display("calendar ended on day %0d weekday %0d at %0d:%0d:%0d, running %0d",
             mday_now, wday_now, hour_now, min_now, sec_now, running_now);
    if (mismatches == 0)
      $display("[millisecond_tick_calendar_clock_unit] OK");
    else
      $display("[millisecond_tick_calendar_clock_unit] ERROR");
    $finish;
  end

endmodule
